// File: rtl/core/crc32_pkg.sv
// shared types, constants and the crc table function for the crc32 byte stream unit
package crc32_pkg;

    localparam int unsigned CRC_W      = 32;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned COUNT_W    = 3;

    localparam logic [CRC_W-1:0]   CRC_POLY   = 32'h04c1_1db7;
    localparam logic [CRC_W-1:0]   CRC_TOP    = 32'h8000_0000;
    localparam logic [COUNT_W-1:0] FULL_COUNT = 3'd4;
    localparam logic [COUNT_W-1:0] LAST_FILL  = 3'd3;

    typedef logic [CRC_W-1:0]   t_crc;
    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [COUNT_W-1:0] t_count;

    // one message byte as it travels from the input register to the update logic
    typedef struct packed {
        t_byte data_byte;
        logic  last_byte;
    } t_byte_req;

    // one finished result
    typedef struct packed {
        t_crc crc_value;
        logic too_short;
    } t_result;

    // non-reflected table entry: idx << 24 divided through the polynomial over eight shifts
    function automatic t_crc crc_table_entry(input t_byte idx);
        t_crc v;
        v = {idx, {(CRC_W-BYTE_W){1'b0}}};
        for (int k = 0; k < BYTE_W; k++) begin
            if ((v & CRC_TOP) != '0) begin
                v = {v[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[CRC_W-2:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

// File: rtl/core/crc32_ifs.sv
// valid/ready stream interfaces for the byte requests and the crc results
interface crc32_in_if;
    logic                 valid;
    logic                 ready;
    logic [7:0]           data_byte;
    logic                 last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface crc32_out_if;
    logic                 valid;
    logic                 ready;
    logic [31:0]          crc_value;
    logic                 too_short;

    modport source (output valid, output crc_value, output too_short, input ready);
    modport sink   (input valid, input crc_value, input too_short, output ready);
endinterface

// File: rtl/core/crc32_in_stage.sv
// input register that holds one byte request until the update logic takes it
module crc32_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  crc32_pkg::t_byte_req i_req,
    output logic                o_req_ready,
    output logic                o_item_valid,
    output crc32_pkg::t_byte_req o_item,
    input  logic                i_item_take
);
    import crc32_pkg::*;

    logic      r_valid;
    logic      n_valid;
    t_byte_req r_item;
    logic      load;

    assign o_req_ready  = !r_valid || i_item_take;
    assign load         = i_req_valid && o_req_ready;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_item_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_req;
        end
    end

endmodule

// File: rtl/core/crc32_core.sv
// remainder register, byte count and the one-byte crc update
module crc32_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_item_valid,
    input  crc32_pkg::t_byte_req i_item,
    input  logic                 i_slot_free,
    output logic                 o_item_take,
    output logic                 o_res_valid,
    output crc32_pkg::t_result   o_res
);
    import crc32_pkg::*;

    t_crc   r_remainder;
    t_crc   n_remainder;
    t_count r_count;
    t_count n_count;
    t_crc   shifted;
    t_crc   upd_rem;
    t_count upd_count;

    // a last byte needs room in the result register, other bytes never wait
    assign o_item_take = i_item_valid && (!i_item.last_byte || i_slot_free);
    assign shifted     = {r_remainder[CRC_W-BYTE_W-1:0], i_item.data_byte};

    always_comb begin
        priority if (r_count < LAST_FILL) begin
            upd_rem   = shifted;
            upd_count = r_count + 3'd1;
        end else if (r_count == LAST_FILL) begin
            upd_rem   = ~shifted;
            upd_count = FULL_COUNT;
        end else begin
            upd_rem   = shifted ^ crc_table_entry(r_remainder[CRC_W-1 -: BYTE_W]);
            upd_count = FULL_COUNT;
        end
    end

    always_comb begin
        n_remainder = r_remainder;
        n_count     = r_count;
        if (o_item_take) begin
            if (i_item.last_byte) begin
                n_remainder = '0;
                n_count     = '0;
            end else begin
                n_remainder = upd_rem;
                n_count     = upd_count;
            end
        end
    end

    assign o_res_valid = o_item_take && i_item.last_byte;

    always_comb begin
        if (upd_count < FULL_COUNT) begin
            o_res.crc_value = '0;
            o_res.too_short = 1'b1;
        end else begin
            o_res.crc_value = ~upd_rem;
            o_res.too_short = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remainder <= '0;
            r_count     <= '0;
        end else begin
            r_remainder <= n_remainder;
            r_count     <= n_count;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("byte count beyond four");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_item_take && i_item.last_byte |=> r_count == '0 && r_remainder == '0)
        else $error("state not cleared after last byte");

    a_fill_to_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_item_take && !i_item.last_byte && r_count >= LAST_FILL |=> r_count == FULL_COUNT)
        else $error("count did not reach full");

    a_last_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item_valid && i_item.last_byte && !i_slot_free |=> $stable(r_remainder)
        && $stable(r_count))
        else $error("state moved while last byte stalled");

endmodule

// File: rtl/core/crc32_out_stage.sv
// result register that holds one crc result until the sink takes it
module crc32_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_res_valid,
    input  crc32_pkg::t_result i_res,
    output logic               o_slot_free,
    output logic               o_rsp_valid,
    output crc32_pkg::t_result o_rsp,
    input  logic               i_rsp_ready
);
    import crc32_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    assign o_slot_free = !r_valid || i_rsp_ready;
    assign o_rsp_valid = r_valid;
    assign o_rsp       = r_res;

    always_comb begin
        n_valid = r_valid;
        if (i_res_valid) begin
            n_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_valid) begin
            r_res <= i_res;
        end
    end

    a_short_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_res.too_short |-> r_res.crc_value == '0)
        else $error("short message with nonzero crc");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> o_slot_free)
        else $error("result written over a pending one");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_rsp_ready |=> r_valid && $stable(r_res))
        else $error("pending result lost");

endmodule

// File: rtl/core/crc32_msb_first_byte_stream_unit.sv
// top level of the msb-first crc-32 byte stream unit
//
//  channel  | dir | payload                     | meaning
//  ---------+-----+-----------------------------+------------------------------------
//  i_req    | in  | data_byte[7:0], last_byte   | one message byte, flag on the last
//  o_rsp    | out | crc_value[31:0], too_short  | one crc per message, after its last
//
// one byte request accepted per cycle, no gaps between messages, unless a result stalls
// a last byte's crc passes from the input register through the update logic
//   into the result register, which drives o_rsp.valid
// the one-byte table update on the remainder register is a register-to-register loop
// synchronous active-low reset clears the remainder, the byte count and both valid bits
// a stalled result only holds back a last byte; ordinary bytes keep flowing past it
module crc32_msb_first_byte_stream_unit (
    input  logic   i_clk,
    input  logic   i_rst_n,
    crc32_in_if.sink    i_req,
    crc32_out_if.source o_rsp
);
    import crc32_pkg::*;

    // request as a struct for the input register
    t_byte_req req_item;
    // request held in the input register
    t_byte_req held_item;
    logic      held_valid;
    // handshake between input register and update logic
    logic      item_take;
    // result from the update logic and room in the result register
    logic      res_valid;
    t_result   res;
    logic      slot_free;
    t_result   rsp;

    assign req_item.data_byte = i_req.data_byte;
    assign req_item.last_byte = i_req.last_byte;

    crc32_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req.valid),
        .i_req        (req_item),
        .o_req_ready  (i_req.ready),
        .o_item_valid (held_valid),
        .o_item       (held_item),
        .i_item_take  (item_take)
    );

    // remainder and count update, result on the last byte
    crc32_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (held_valid),
        .i_item       (held_item),
        .i_slot_free  (slot_free),
        .o_item_take  (item_take),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    crc32_out_stage u_out_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_res_valid  (res_valid),
        .i_res        (res),
        .o_slot_free  (slot_free),
        .o_rsp_valid  (o_rsp.valid),
        .o_rsp        (rsp),
        .i_rsp_ready  (o_rsp.ready)
    );

    assign o_rsp.crc_value = rsp.crc_value;
    assign o_rsp.too_short = rsp.too_short;

endmodule

// File: tb/sv/crc32_stream_checker.sv
`timescale 1ns / 100ps
// scoreboard that predicts the crc of every message and compares the unit's results
module crc32_stream_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    crc32_in_if   req_mon,
    crc32_out_if  rsp_mon,
    output int    o_pending,
    output int    o_fail_count
);
    import crc32_pkg::*;

    t_crc    msg_rem;
    t_count  msg_len;
    t_result crc_expected_q[$];
    int      fail_total = 0;

    // remainder of the top byte, shifted to bit 31, after eight steps of division
    function automatic t_crc top_byte_residue(input t_byte top);
        t_crc acc;
        acc = {top, 24'h00_0000};
        for (int i = 0; i < BYTE_W; i++) begin
            if (acc[CRC_W-1]) begin
                acc = {acc[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                acc = {acc[CRC_W-2:0], 1'b0};
            end
        end
        return acc;
    endfunction

    task automatic note_fail(input string what, input t_result want, input t_result got);
        fail_total++;
        o_fail_count = fail_total;
        if (fail_total <= 10) begin
            $display("%0t: %s: expected crc %08h short %0b, got crc %08h short %0b",
                     $realtime, what, want.crc_value, want.too_short,
                     got.crc_value, got.too_short);
        end
    endtask

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
        msg_rem      = '0;
        msg_len      = '0;
    end

    always @(posedge i_clk) begin
        t_crc    shifted;
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            msg_rem = '0;
            msg_len = '0;
            crc_expected_q.delete();
        end else begin
            if (rsp_mon.valid && rsp_mon.ready) begin
                got.crc_value = rsp_mon.crc_value;
                got.too_short = rsp_mon.too_short;
                if (crc_expected_q.size() == 0) begin
                    want = '0;
                    note_fail("result with no message pending", want, got);
                end else begin
                    want = crc_expected_q.pop_front();
                    if (got.crc_value !== want.crc_value) begin
                        note_fail("crc_value differs", want, got);
                    end else if (got.too_short !== want.too_short) begin
                        note_fail("too_short differs", want, got);
                    end
                end
            end
            if (req_mon.valid && req_mon.ready) begin
                shifted = {msg_rem[CRC_W-BYTE_W-1:0], req_mon.data_byte};
                if (msg_len < LAST_FILL) begin
                    msg_rem = shifted;
                    msg_len = msg_len + 1'b1;
                end else if (msg_len == LAST_FILL) begin
                    msg_rem = ~shifted;
                    msg_len = FULL_COUNT;
                end else begin
                    msg_rem = shifted ^ top_byte_residue(msg_rem[CRC_W-1 -: BYTE_W]);
                end
                if (req_mon.last_byte) begin
                    if (msg_len < FULL_COUNT) begin
                        want.crc_value = '0;
                        want.too_short = 1'b1;
                    end else begin
                        want.crc_value = ~msg_rem;
                        want.too_short = 1'b0;
                    end
                    crc_expected_q = {crc_expected_q, want};
                    msg_rem = '0;
                    msg_len = '0;
                end
            end
        end
        o_pending = crc_expected_q.size();
    end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// stimulus, clock, reset and verdict for the crc32 byte stream unit
module tb;
    import crc32_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n;

    crc32_in_if  req_bus ();
    crc32_out_if rsp_bus ();

    int pending;
    int fail_count;

    // sender may idle between bytes unless this is set for the current message
    bit send_quiet;

    // 8 ns clock
    always #4 i_clk = ~i_clk;

    crc32_msb_first_byte_stream_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    // watches both channels, predicts and compares
    crc32_stream_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .req_mon      (req_bus),
        .rsp_mon      (rsp_bus),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // offer one byte request, possibly after a random gap, and hold it until taken
    task automatic push_byte(input t_byte b, input logic is_last);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid     <= 1'b1;
        req_bus.data_byte <= b;
        req_bus.last_byte <= is_last;
        do @(posedge i_clk); while (!(req_bus.valid && req_bus.ready));
    endtask

    // one whole message, flag on its final byte
    task automatic push_message(input t_byte msg[$]);
        send_quiet = ($urandom_range(0, 2) == 0);
        foreach (msg[i]) begin
            push_byte(msg[i], i == msg.size() - 1);
        end
    endtask

    // sender: directed messages, then random ones, then drain
    initial begin
        t_byte msg[$];
        int    bytes_sent;
        int    msg_len;
        int    pick;
        int    fill_kind;

        // every input known before the first edge
        req_bus.valid     <= 1'b0;
        req_bus.data_byte <= '0;
        req_bus.last_byte <= 1'b0;
        i_rst_n           <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // short messages of one, two and three bytes
        push_message('{8'hFF});
        push_message('{8'h00, 8'hFF});
        push_message('{8'h80, 8'h01, 8'h7F});
        // exactly four bytes: only the complemented fill, no table step
        push_message('{8'hFF, 8'hFF, 8'hFF, 8'hFF});
        // first table step, all zero data
        push_message('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        // longer message with single-bit and alternating patterns
        push_message('{8'hFF, 8'h00, 8'h80, 8'h01, 8'hAA, 8'h55, 8'hFE, 8'h7F});
        bytes_sent = 23;

        // random messages: mostly short to hit the fill phase often, a few long
        while (bytes_sent < 1450) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                msg_len = $urandom_range(1, 6);
            end else if (pick < 92) begin
                msg_len = $urandom_range(7, 24);
            end else begin
                msg_len = $urandom_range(25, 80);
            end
            fill_kind = $urandom_range(0, 19);
            msg.delete();
            for (int i = 0; i < msg_len; i++) begin
                case (fill_kind)
                    0: begin
                        msg = {msg, 8'h00};
                    end
                    1: begin
                        msg = {msg, 8'hFF};
                    end
                    default: begin
                        msg = {msg, t_byte'($urandom_range(0, 255))};
                    end
                endcase
            end
            push_message(msg);
            bytes_sent += msg_len;
        end
        req_bus.valid <= 1'b0;

        // wait for every predicted crc, sampled away from the active edge
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        // a stray late result would show up within this wait
        repeat (4) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("crc32_msb_first_byte_stream_unit: match");
        end else begin
            $display("crc32_msb_first_byte_stream_unit: mismatch");
        end
        $finish;
    end

    // receiver: random back-pressure per result, quiet stretches, one long hold-off
    initial begin
        int hold;
        int taken;
        bit quiet;
        rsp_bus.ready <= 1'b0;
        taken = 0;
        quiet = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (taken % 16 == 0) begin
                quiet = ($urandom_range(0, 2) == 0);
            end
            hold = quiet ? 0 : $urandom_range(0, 11);
            // long stall so the unit backs up and stops taking bytes
            if (taken == 25) begin
                hold = 300;
            end
            if (hold > 0) begin
                rsp_bus.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            rsp_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!(rsp_bus.valid && rsp_bus.ready));
            taken++;
        end
    end

    // hard limit on the run
    initial begin
        #2_000_000;
        $display("crc32_msb_first_byte_stream_unit: mismatch");
        $finish;
    end

endmodule

// File: crc32_msb_first_byte_stream_unit.f
rtl/core/crc32_pkg.sv
rtl/core/crc32_ifs.sv
rtl/core/crc32_in_stage.sv
rtl/core/crc32_core.sv
rtl/core/crc32_out_stage.sv
rtl/core/crc32_msb_first_byte_stream_unit.sv
tb/sv/crc32_stream_checker.sv
tb/sv/tb.sv
